/* sv/ppi_port_io_decoder_unit_macros.svh */
// Assertion macros shared by the parallel port decoder modules.
`ifndef PPI_PORT_IO_DECODER_UNIT_MACROS_SVH
`define PPI_PORT_IO_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PPI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define PPI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ppi_pkg.sv */
// Shared types and constants for the parallel port decoder.
package ppi_pkg;

    localparam int KIND_W = 4;

    // Request kinds produced by the front decoder
    localparam logic [KIND_W-1:0] KIND_RD_A    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RD_B    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_RD_C    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_RD_FF   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_WR_A    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_WR_B    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_WR_C    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_WR_MODE = 4'd7;
    localparam logic [KIND_W-1:0] KIND_WR_BSR  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_WR_NONE = 4'd9;

    // Port select codes, port_high bits 1:0
    localparam logic [1:0] SEL_A    = 2'd0;
    localparam logic [1:0] SEL_B    = 2'd1;
    localparam logic [1:0] SEL_C    = 2'd2;
    localparam logic [1:0] SEL_CTRL = 2'd3;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINTER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMPER  = 1'd1;

    localparam logic [6:0] JUMPER_RESET = 7'd30;
    localparam logic [7:0] MODE_RESET   = 8'h9B;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        wdata;
        logic [7:0]        bus;
        logic              tape;
        logic              vsync;
    } cmd_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic [3:0] keyboard_row;
        logic       tape_motor_on;
        logic [1:0] psg_control;
        logic       psg_write_strobe;
        logic [7:0] psg_write_data;
    } res_t;

endpackage

/* sv/ppi_front.sv */
// Front decoder: classifies one bus access into a request kind.
module ppi_front (
    input  logic             op,
    input  logic [7:0]       port_high,
    input  logic [7:0]       wdata,
    input  logic [7:0]       psg_bus_value,
    input  logic             tape_level,
    input  logic             vsync_active,
    output ppi_pkg::cmd_t    cmd
);

    logic [ppi_pkg::KIND_W-1:0] kind;

    always_comb
    begin
        kind = ppi_pkg::KIND_RD_FF;
        if (op == ppi_pkg::OP_READ)
        begin
            // video controller space or external peripheral reads give 0xFF
            if (port_high[6] && !port_high[3])
            begin
                case (port_high[1:0])
                    ppi_pkg::SEL_A: kind = ppi_pkg::KIND_RD_A;
                    ppi_pkg::SEL_B: kind = ppi_pkg::KIND_RD_B;
                    ppi_pkg::SEL_C: kind = ppi_pkg::KIND_RD_C;
                    default:        kind = ppi_pkg::KIND_RD_FF;
                endcase
            end
        end
        else if (!port_high[3])
        begin
            case (port_high[1:0])
                ppi_pkg::SEL_A: kind = ppi_pkg::KIND_WR_A;
                ppi_pkg::SEL_B: kind = ppi_pkg::KIND_WR_B;
                ppi_pkg::SEL_C: kind = ppi_pkg::KIND_WR_C;
                default:        kind = wdata[7] ? ppi_pkg::KIND_WR_MODE
                                                : ppi_pkg::KIND_WR_BSR;
            endcase
        end
        else
        begin
            kind = ppi_pkg::KIND_WR_NONE;
        end
    end

    assign cmd.kind  = kind;
    assign cmd.wdata = wdata;
    assign cmd.bus   = psg_bus_value;
    assign cmd.tape  = tape_level;
    assign cmd.vsync = vsync_active;

endmodule

/* sv/ppi_fifo.sv */
// Small first-in first-out queue of packed words.
`include "ppi_port_io_decoder_unit_macros.svh"

module ppi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en, rd_en;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = mem[rd_ptr_reg];

    `PPI_ASSERT_IMP(a_fifo_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "fifo count overrun")
    `PPI_ASSERT_NXT(a_fifo_fill, wr_en && !rd_en, count_reg == $past(count_reg) + 1'b1,
                    "fifo count did not rise on push")
    `PPI_ASSERT_NXT(a_fifo_drain, rd_en && !wr_en, count_reg == $past(count_reg) - 1'b1,
                    "fifo count did not fall on pop")

endmodule

/* sv/ppi_back.sv */
// Back end: port latches, mode word, config, and per-request execution.
`include "ppi_port_io_decoder_unit_macros.svh"

module ppi_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            cmd_valid,
    input  ppi_pkg::cmd_t                   cmd,
    output logic                            cmd_pop,
    input  logic                            res_full,
    output logic                            res_push,
    output ppi_pkg::res_t                   res
);

    logic       printer_reg;
    logic [6:0] jumper_reg;
    logic [7:0] latch_a_reg, latch_a_next;
    logic [7:0] latch_b_reg, latch_b_next;
    logic [7:0] latch_c_reg, latch_c_next;
    logic [7:0] mode_reg, mode_next;
    logic [3:0] key_reg, key_next;
    logic       motor_reg, motor_next;

    logic       fire;
    logic [7:0] rdata, sdata, port_c_rd, c_new, bit_mask;
    logic [1:0] ctl;
    logic       strobe, c_update;

    assign fire     = cmd_valid && !res_full;
    assign cmd_pop  = fire;
    assign res_push = fire;

    // Port C read with direction masking; upper pattern 11 reads as 10
    always_comb
    begin
        ctl       = (latch_c_reg[7:6] == 2'b11) ? 2'b10 : latch_c_reg[7:6];
        port_c_rd = latch_c_reg;
        if (mode_reg[3])
        begin
            port_c_rd = {ctl, 1'b1, motor_reg, latch_c_reg[3:0]};
            if (!mode_reg[0])
                port_c_rd[3:0] = 4'hF;
        end
    end

    assign bit_mask = 8'd1 << cmd.wdata[3:1];

    always_comb
    begin
        latch_a_next = latch_a_reg;
        latch_b_next = latch_b_reg;
        latch_c_next = latch_c_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        motor_next   = motor_reg;
        rdata        = 8'h00;
        strobe       = 1'b0;
        sdata        = 8'h00;
        c_update     = 1'b0;
        c_new        = latch_c_reg;

        case (cmd.kind)
            ppi_pkg::KIND_RD_A:
                rdata = mode_reg[4] ? cmd.bus : latch_a_reg;
            ppi_pkg::KIND_RD_B:
                rdata = mode_reg[1] ? ({cmd.tape, ~printer_reg, 6'd0}
                                       | {1'b0, jumper_reg} | {7'd0, cmd.vsync})
                                    : latch_b_reg;
            ppi_pkg::KIND_RD_C:
                rdata = port_c_rd;
            ppi_pkg::KIND_RD_FF:
                rdata = 8'hFF;
            ppi_pkg::KIND_WR_A:
            begin
                latch_a_next = cmd.wdata;
                if (!mode_reg[4])
                begin
                    strobe = 1'b1;
                    sdata  = cmd.wdata;
                end
            end
            ppi_pkg::KIND_WR_B:
                latch_b_next = cmd.wdata;
            ppi_pkg::KIND_WR_C:
            begin
                c_new    = cmd.wdata;
                c_update = 1'b1;
            end
            ppi_pkg::KIND_WR_MODE:
            begin
                mode_next    = cmd.wdata;
                latch_a_next = 8'h00;
                latch_b_next = 8'h00;
                latch_c_next = 8'h00;
            end
            ppi_pkg::KIND_WR_BSR:
            begin
                c_new    = cmd.wdata[0] ? (latch_c_reg | bit_mask)
                                        : (latch_c_reg & ~bit_mask);
                c_update = 1'b1;
            end
            default:
                rdata = 8'h00;
        endcase

        if (c_update)
        begin
            latch_c_next = c_new;
            if (!mode_reg[0])
                key_next = c_new[3:0];
            if (!mode_reg[3])
            begin
                motor_next = c_new[4];
                strobe     = 1'b1;
                sdata      = latch_a_reg;
            end
        end
    end

    assign res.rdata            = rdata;
    assign res.keyboard_row     = key_next;
    assign res.tape_motor_on    = motor_next;
    assign res.psg_control      = latch_c_next[7:6];
    assign res.psg_write_strobe = strobe;
    assign res.psg_write_data   = sdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_a_reg <= 8'h00;
            latch_b_reg <= 8'h00;
            latch_c_reg <= 8'h00;
            mode_reg    <= ppi_pkg::MODE_RESET;
            key_reg     <= 4'h0;
            motor_reg   <= 1'b0;
        end
        else if (fire)
        begin
            latch_a_reg <= latch_a_next;
            latch_b_reg <= latch_b_next;
            latch_c_reg <= latch_c_next;
            mode_reg    <= mode_next;
            key_reg     <= key_next;
            motor_reg   <= motor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            printer_reg <= 1'b0;
            jumper_reg  <= ppi_pkg::JUMPER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ppi_pkg::CFG_PRINTER: printer_reg <= cfg_data[0];
                ppi_pkg::CFG_JUMPER:  jumper_reg  <= cfg_data;
                default:              printer_reg <= printer_reg;
            endcase
        end
    end

    `PPI_ASSERT_NXT(a_mode_clears, fire && cmd.kind == ppi_pkg::KIND_WR_MODE,
                    latch_a_reg == 8'h00 && latch_b_reg == 8'h00 && latch_c_reg == 8'h00,
                    "mode write left a latch set")
    `PPI_ASSERT_NXT(a_read_keeps, fire && (cmd.kind == ppi_pkg::KIND_RD_A ||
                    cmd.kind == ppi_pkg::KIND_RD_B || cmd.kind == ppi_pkg::KIND_RD_C ||
                    cmd.kind == ppi_pkg::KIND_RD_FF),
                    $stable(key_reg) && $stable(motor_reg) && $stable(latch_c_reg),
                    "read request changed port state")
    `PPI_ASSERT_IMP(a_strobe_src, strobe,
                    cmd.kind == ppi_pkg::KIND_WR_A || cmd.kind == ppi_pkg::KIND_WR_C ||
                    cmd.kind == ppi_pkg::KIND_WR_BSR, "strobe from a request that cannot give one")

endmodule

/* sv/ppi_port_io_decoder_unit.sv */
// Top level of the parallel port I/O decoder: front decode, request queue, back end.
//
//  channel   handshake          payload
//  -------   ---------          -------
//  config    cfg_write          cfg_index, cfg_data (0 printer_attached, 1 jumper_bits)
//  access    push / full        op, port_high, wdata, psg_bus_value, tape_level, vsync_active
//  result    pop / empty        rdata, keyboard_row, tape_motor_on, psg_control,
//                               psg_write_strobe, psg_write_data
//
// One access a cycle sustained while the consumer keeps popping. An access pushed in
// enters the request queue, is executed by the back end from its head and its result is
// written into the result queue and shows at its head; both queues set the delay.
// Reset (rst_n low, asynchronous) empties both queues, sets the mode word to all
// ports input and the jumper bits to 30.
// A held-off result queue stalls only the back end; the front keeps taking requests
// until the request queue fills, then full rises.
module ppi_port_io_decoder_unit #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            op,
    input  logic [7:0]                      port_high,
    input  logic [7:0]                      wdata,
    input  logic [7:0]                      psg_bus_value,
    input  logic                            tape_level,
    input  logic                            vsync_active,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      rdata,
    output logic [3:0]                      keyboard_row,
    output logic                            tape_motor_on,
    output logic [1:0]                      psg_control,
    output logic                            psg_write_strobe,
    output logic [7:0]                      psg_write_data
);

    localparam int CMD_W = $bits(ppi_pkg::cmd_t);
    localparam int RES_W = $bits(ppi_pkg::res_t);

    ppi_pkg::cmd_t cmd_in, cmd_head;
    ppi_pkg::res_t res_in, res_head;
    logic          cmd_empty, cmd_pop;
    logic          res_full, res_push;

    // decode the access as it arrives
    ppi_front u_front (
        .op            (op),
        .port_high     (port_high),
        .wdata         (wdata),
        .psg_bus_value (psg_bus_value),
        .tape_level    (tape_level),
        .vsync_active  (vsync_active),
        .cmd           (cmd_in)
    );

    // request queue parting front and back
    ppi_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    // port state and execution, one request a cycle while requests wait and the result queue has room
    ppi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue towards the consumer
    ppi_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign rdata            = res_head.rdata;
    assign keyboard_row     = res_head.keyboard_row;
    assign tape_motor_on    = res_head.tape_motor_on;
    assign psg_control      = res_head.psg_control;
    assign psg_write_strobe = res_head.psg_write_strobe;
    assign psg_write_data   = res_head.psg_write_data;

endmodule

/* dv/ppi_port_io_decoder_unit_test.sv */
// Self-checking testbench for the parallel port I/O decoder: directed table, then random accesses.
`timescale 1ns / 1ps

module ppi_port_io_decoder_unit_test;

    // Run limits and timing
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned HOLD_CYCLES   = 64;   // long result hold-off, fills both queues
    localparam int unsigned SETTLE_CYCLES = 6;    // margin for the pipe to settle
    localparam int unsigned PHASE_ITEMS   = 230;
    localparam int unsigned PRINT_CAP     = 30;

    // Mode word bits: 1 means the port (or half of port C) is input
    localparam int MODE_C_LO_IN = 0;
    localparam int MODE_B_IN    = 1;
    localparam int MODE_C_HI_IN = 3;
    localparam int MODE_A_IN    = 4;

    // One directed request; fixed is set where the expected result is typed in
    typedef struct packed {
        logic          op;
        logic [7:0]    port;
        logic [7:0]    data;
        logic [7:0]    bus;
        logic          tape;
        logic          vsync;
        logic          fixed;
        ppi_pkg::res_t want;
    } access_row_t;

    localparam int N_DIRECTED = 25;
    localparam access_row_t DIRECTED [N_DIRECTED] = '{
        // reads straight after reset: all ports input
        '{ppi_pkg::OP_READ,  8'h41, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1,
          '{8'hDF, 4'h0, 1'b0, 2'd0, 1'b0, 8'h00}},          // B: tape, ready, jumpers, vsync
        '{ppi_pkg::OP_READ,  8'h40, 8'h00, 8'hA5, 1'b0, 1'b0, 1'b1,
          '{8'hA5, 4'h0, 1'b0, 2'd0, 1'b0, 8'h00}},          // A follows the sound chip bus
        '{ppi_pkg::OP_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'hFF, 4'h0, 1'b0, 2'd0, 1'b0, 8'h00}},          // video controller space
        '{ppi_pkg::OP_READ,  8'h48, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'hFF, 4'h0, 1'b0, 2'd0, 1'b0, 8'h00}},          // external peripheral
        '{ppi_pkg::OP_READ,  8'h43, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'hFF, 4'h0, 1'b0, 2'd0, 1'b0, 8'h00}},          // control port
        '{ppi_pkg::OP_READ,  8'h42, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'h20, 4'h0, 1'b0, 2'd0, 1'b0, 8'h00}},          // C, both halves input
        // mode write with bit 6 low still decodes
        '{ppi_pkg::OP_WRITE, 8'h03, 8'h80, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'h00, 4'h0, 1'b0, 2'd0, 1'b0, 8'h00}},
        '{ppi_pkg::OP_WRITE, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'h00, 4'h0, 1'b0, 2'd0, 1'b1, 8'hFF}},          // A out: strobe with data
        '{ppi_pkg::OP_WRITE, 8'hF2, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'h00, 4'hF, 1'b1, 2'd3, 1'b1, 8'hFF}},          // C out: row, motor, strobe
        '{ppi_pkg::OP_READ,  8'h42, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          '{8'hFF, 4'hF, 1'b1, 2'd3, 1'b0, 8'h00}},          // C out reads its latch
        // rest checked against the predictor
        '{ppi_pkg::OP_WRITE, 8'h03, 8'h0E, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // bit reset, C bit 7
        '{ppi_pkg::OP_WRITE, 8'h01, 8'h5A, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ppi_pkg::OP_READ,  8'h41, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, '0},   // B out reads latch
        '{ppi_pkg::OP_READ,  8'h40, 8'h00, 8'h3C, 1'b0, 1'b0, 1'b0, '0},   // A out reads latch
        '{ppi_pkg::OP_WRITE, 8'h43, 8'h89, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // both C halves in
        '{ppi_pkg::OP_WRITE, 8'h03, 8'h0F, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // bit set, C bit 7
        '{ppi_pkg::OP_WRITE, 8'h03, 8'h0D, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // bit set, C bit 6
        '{ppi_pkg::OP_READ,  8'h42, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // control 11 reads 10
        '{ppi_pkg::OP_WRITE, 8'h03, 8'h88, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // lower C out
        '{ppi_pkg::OP_WRITE, 8'h02, 8'h07, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ppi_pkg::OP_READ,  8'h42, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // lower nibble F
        '{ppi_pkg::OP_WRITE, 8'h03, 8'h9B, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // back to all input
        '{ppi_pkg::OP_WRITE, 8'h00, 8'hC3, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // A in: no strobe
        '{ppi_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, '0},   // bit 3 high: ignored
        '{ppi_pkg::OP_READ,  8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, '0}
    };

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write;
    logic [ppi_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ppi_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           push;
    logic                           full;
    logic                           op;
    logic [7:0]                     port_high;
    logic [7:0]                     wdata;
    logic [7:0]                     psg_bus_value;
    logic                           tape_level;
    logic                           vsync_active;
    logic                           empty;
    logic                           pop;
    logic [7:0]                     rdata;
    logic [3:0]                     keyboard_row;
    logic                           tape_motor_on;
    logic [1:0]                     psg_control;
    logic                           psg_write_strobe;
    logic [7:0]                     psg_write_data;

    // Predictor copy of the interface state and settings
    logic [7:0] port_a_q;
    logic [7:0] port_b_q;
    logic [7:0] port_c_q;
    logic [7:0] ctrl_word_q;
    logic [3:0] key_row_q;
    logic       motor_q;
    logic       printer_q;
    logic [6:0] jumper_q;

    ppi_pkg::res_t results_due[$];   // expected results, oldest first
    int unsigned   fail_count    = 0;
    int unsigned   cycle_count   = 0;
    int unsigned   send_idle_pct = 18;
    int unsigned   recv_idle_pct = 49;
    int unsigned   hold_gen      = 0;   // bumped to ask the receiver for a long hold-off

    ppi_port_io_decoder_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .push             (push),
        .full             (full),
        .op               (op),
        .port_high        (port_high),
        .wdata            (wdata),
        .psg_bus_value    (psg_bus_value),
        .tape_level       (tape_level),
        .vsync_active     (vsync_active),
        .empty            (empty),
        .pop              (pop),
        .rdata            (rdata),
        .keyboard_row     (keyboard_row),
        .tape_motor_on    (tape_motor_on),
        .psg_control      (psg_control),
        .psg_write_strobe (psg_write_strobe),
        .psg_write_data   (psg_write_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop, far beyond the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch %s: got %02h, expected %02h", $realtime, what, got, exp);
        fail_count++;
    endtask

    // Push port C latch to its output halves; 1 when the sound chip gets a strobe.
    function automatic logic drive_port_c();
        if (!ctrl_word_q[MODE_C_LO_IN])
            key_row_q = port_c_q[3:0];
        if (!ctrl_word_q[MODE_C_HI_IN])
        begin
            motor_q = port_c_q[4];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Expected result of one bus access; updates the predictor state.
    function automatic ppi_pkg::res_t decode_access(input logic op_v, input logic [7:0] ph,
                                                    input logic [7:0] wd, input logic [7:0] bus,
                                                    input logic tape, input logic vs);
        ppi_pkg::res_t res;
        logic [7:0]    c_view;
        logic [1:0]    c_ctl;
        logic          strobe;
        logic [7:0]    strobe_data;
        res         = '0;
        strobe      = 1'b0;
        strobe_data = 8'h00;
        if (op_v == ppi_pkg::OP_READ)
        begin
            res.rdata = 8'hFF;
            // bit 6 low is video controller space, bit 3 high is off the interface
            if (ph[6] && !ph[3])
            begin
                case (ph[1:0])
                    ppi_pkg::SEL_A:
                        res.rdata = ctrl_word_q[MODE_A_IN] ? bus : port_a_q;
                    ppi_pkg::SEL_B:
                        if (ctrl_word_q[MODE_B_IN])
                            res.rdata = {tape, 7'd0} | {1'b0, ~printer_q, 6'd0}
                                      | {1'b0, jumper_q} | {7'd0, vs};
                        else
                            res.rdata = port_b_q;
                    ppi_pkg::SEL_C:
                    begin
                        c_view = port_c_q;
                        if (ctrl_word_q[MODE_C_HI_IN])
                        begin
                            c_ctl  = (port_c_q[7:6] == 2'b11) ? 2'b10 : port_c_q[7:6];
                            c_view = {c_ctl, 1'b1, motor_q, port_c_q[3:0]};
                            if (!ctrl_word_q[MODE_C_LO_IN])
                                c_view[3:0] = 4'hF;
                        end
                        res.rdata = c_view;
                    end
                    default: ;
                endcase
            end
        end
        else if (!ph[3])
        begin
            case (ph[1:0])
                ppi_pkg::SEL_A:
                begin
                    port_a_q = wd;
                    if (!ctrl_word_q[MODE_A_IN])
                    begin
                        strobe      = 1'b1;
                        strobe_data = wd;
                    end
                end
                ppi_pkg::SEL_B:
                    port_b_q = wd;
                ppi_pkg::SEL_C:
                begin
                    port_c_q = wd;
                    strobe   = drive_port_c();
                end
                default:
                begin
                    if (wd[7])
                    begin
                        // mode write: latches cleared, row and motor kept
                        ctrl_word_q = wd;
                        port_a_q    = 8'h00;
                        port_b_q    = 8'h00;
                        port_c_q    = 8'h00;
                    end
                    else
                    begin
                        port_c_q[wd[3:1]] = wd[0];
                        strobe            = drive_port_c();
                    end
                end
            endcase
            if (strobe && ph[1:0] != ppi_pkg::SEL_A)
                strobe_data = port_a_q;
        end
        res.keyboard_row     = key_row_q;
        res.tape_motor_on    = motor_q;
        res.psg_control      = port_c_q[7:6];
        res.psg_write_strobe = strobe;
        res.psg_write_data   = strobe ? strobe_data : 8'h00;
        return res;
    endfunction

    // Offer one request, wait for it to be taken, log the expected result.
    // push is left high so back-to-back requests never drop it.
    task automatic send_access(input logic op_v, input logic [7:0] ph_v, input logic [7:0] wd_v,
                               input logic [7:0] bus_v, input logic tape_v, input logic vs_v,
                               input logic fixed, input ppi_pkg::res_t fixed_res);
        ppi_pkg::res_t forecast;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        op            <= op_v;
        port_high     <= ph_v;
        wdata         <= wd_v;
        psg_bus_value <= bus_v;
        tape_level    <= tape_v;
        vsync_active  <= vs_v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        forecast = decode_access(op_v, ph_v, wd_v, bus_v, tape_v, vs_v);
        results_due.push_back(fixed ? fixed_res : forecast);
    endtask

    // Stop offering, let every outstanding result come out, then allow the pipe to settle.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers; only called with the block idle.
    task automatic apply_settings(input logic printer_v, input logic [6:0] jumper_v);
        cfg_write <= 1'b1;
        cfg_index <= ppi_pkg::CFG_PRINTER;
        cfg_data  <= {6'd0, printer_v};
        @(posedge clk);
        cfg_index <= ppi_pkg::CFG_JUMPER;
        cfg_data  <= jumper_v;
        @(posedge clk);
        cfg_write <= 1'b0;
        printer_q = printer_v;
        jumper_q  = jumper_v;
        @(posedge clk);
    endtask

    // Random requests, mostly decoding onto the interface; mode writes kept rare
    // so that the latches get a chance to build up state between clears.
    task automatic run_random_phase(input int unsigned count, input bit with_hold);
        logic       op_v;
        logic [7:0] ph_v;
        logic [7:0] wd_v;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (with_hold && n == count / 4)
                hold_gen++;
            op_v = 1'($urandom_range(1));
            ph_v = 8'($urandom_range(255));
            wd_v = 8'($urandom_range(255));
            if ($urandom_range(99) < 80)
            begin
                ph_v[3] = 1'b0;
                if (op_v == ppi_pkg::OP_READ)
                    ph_v[6] = 1'b1;
            end
            if (op_v == ppi_pkg::OP_WRITE && ph_v[1:0] == ppi_pkg::SEL_CTRL && wd_v[7]
                && $urandom_range(3) != 0)
                wd_v[7] = 1'b0;
            send_access(op_v, ph_v, wd_v, 8'($urandom_range(255)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'b0, '0);
        end
    endtask

    // Receiver: random pop, plus a long hold-off whenever hold_gen moves on
    initial
    begin : result_taker
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_gen != hold_seen)
            begin
                hold_seen = hold_gen;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        ppi_pkg::res_t seen;
        ppi_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            seen.rdata            = rdata;
            seen.keyboard_row     = keyboard_row;
            seen.tape_motor_on    = tape_motor_on;
            seen.psg_control      = psg_control;
            seen.psg_write_strobe = psg_write_strobe;
            seen.psg_write_data   = psg_write_data;
            if (results_due.size() == 0)
                report_mismatch("result with no request outstanding", seen.rdata, 8'h00);
            else
            begin
                want = results_due.pop_front();
                if (seen.rdata !== want.rdata)
                    report_mismatch("rdata", seen.rdata, want.rdata);
                if (seen.keyboard_row !== want.keyboard_row)
                    report_mismatch("keyboard_row", 8'(seen.keyboard_row),
                                    8'(want.keyboard_row));
                if (seen.tape_motor_on !== want.tape_motor_on)
                    report_mismatch("tape_motor_on", 8'(seen.tape_motor_on),
                                    8'(want.tape_motor_on));
                if (seen.psg_control !== want.psg_control)
                    report_mismatch("psg_control", 8'(seen.psg_control),
                                    8'(want.psg_control));
                if (seen.psg_write_strobe !== want.psg_write_strobe)
                    report_mismatch("psg_write_strobe", 8'(seen.psg_write_strobe),
                                    8'(want.psg_write_strobe));
                if (seen.psg_write_data !== want.psg_write_data)
                    report_mismatch("psg_write_data", seen.psg_write_data, want.psg_write_data);
            end
        end
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = ppi_pkg::CFG_PRINTER;
        cfg_data      = '0;
        push          = 1'b0;
        op            = ppi_pkg::OP_READ;
        port_high     = 8'h00;
        wdata         = 8'h00;
        psg_bus_value = 8'h00;
        tape_level    = 1'b0;
        vsync_active  = 1'b0;

        // predictor at its reset state
        port_a_q    = 8'h00;
        port_b_q    = 8'h00;
        port_c_q    = 8'h00;
        ctrl_word_q = ppi_pkg::MODE_RESET;
        key_row_q   = 4'h0;
        motor_q     = 1'b0;
        printer_q   = 1'b0;
        jumper_q    = ppi_pkg::JUMPER_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset settings, sender 18 / receiver 49 idling
        for (int k = 0; k < N_DIRECTED; k++)
            send_access(DIRECTED[k].op, DIRECTED[k].port, DIRECTED[k].data, DIRECTED[k].bus,
                        DIRECTED[k].tape, DIRECTED[k].vsync, DIRECTED[k].fixed,
                        DIRECTED[k].want);
        drain_results();

        // printer on, every jumper set; includes a long hold-off
        apply_settings(1'b1, 7'h7F);
        run_random_phase(PHASE_ITEMS, 1'b1);
        drain_results();

        // idling swapped, settings at the low extreme
        send_idle_pct = 49;
        recv_idle_pct = 18;
        apply_settings(1'b0, 7'h00);
        run_random_phase(PHASE_ITEMS, 1'b0);
        drain_results();

        // full rate both sides, random settings, another hold-off to fill the queues
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(1'($urandom_range(1)), 7'($urandom_range(127)));
        run_random_phase(PHASE_ITEMS, 1'b1);
        drain_results();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/ppi_pkg.sv
sv/ppi_front.sv
sv/ppi_fifo.sv
sv/ppi_back.sv
sv/ppi_port_io_decoder_unit.sv
dv/ppi_port_io_decoder_unit_test.sv
